@@ hdl/lfog_pkg.sv @@
// ----------------------------------------------------------------------------
// lfog_pkg
// Shared widths, register indexes, lane control and sequencer types for the
// linear fade-out gain block.
// ----------------------------------------------------------------------------
package lfog_pkg;

  // Sample and register widths
  localparam int SAMPLE_BITS = 16;
  localparam int TRACK_W     = 32;
  localparam int FADE_W      = 24;
  localparam int CFG_W       = 32;
  localparam int REG_IDX_W   = 1;

  // Product of a magnitude and a remaining-frame count
  localparam int PROD_W  = SAMPLE_BITS + FADE_W;
  // Stream payload: two samples, padded to whole bytes
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int TUSER_W = 2;
  // Divide step counter, holds 0..SAMPLE_BITS
  localparam int STEP_W  = $clog2(SAMPLE_BITS + 1);

  // tuser bit positions
  localparam int USER_FADING   = 0;
  localparam int USER_PAST_END = 1;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TRACK_LEN = 1'b0,
    REG_FADE_LEN  = 1'b1
  } reg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  // Control shared by both lanes
  typedef struct packed {
    logic load;  // capture a new item
    logic mult;  // form magnitude times remaining count
    logic step;  // one restoring divide step
  } lane_ctrl_t;

endpackage

@@ hdl/linear_fade_out_gain.sv @@
// ----------------------------------------------------------------------------
// linear_fade_out_gain
// Linear fade-out over the last frames of a stereo track of known length.
// ----------------------------------------------------------------------------
// Each accepted item is one stereo frame and gives one result item. A frame
// passes through these steps: the accepting edge captures it, then one
// multiply, then SAMPLE_BITS restoring divide steps run side by side in the
// left and right lanes, then it moves into the output register, waiting in
// the last divide step until that register is free. A new frame is taken
// once the previous one has left the lanes, so the block takes no new frame
// before it is through with the previous one; the output register lets it
// enter while a result waits. Writing track_length reloads the frames-remaining
// counter; fade_length takes effect on the next frame. Frames past the end
// come out as silence with the past-end flag. Registers must be written only
// while the block is idle; the block itself does not enforce it.
module linear_fade_out_gain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [lfog_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfog_pkg::CFG_W-1:0]        cfg_data_i,
  // Input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lfog_pkg::TDATA_W-1:0]      s_tdata,   // left_in, right_in
  // Result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lfog_pkg::TDATA_W-1:0]      m_tdata,   // left_out, right_out
  output logic                              m_tlast,   // last_frame
  output logic [lfog_pkg::TUSER_W-1:0]      m_tuser    // fading, past_end
);
  import lfog_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_BITS);

  logic [TRACK_W-1:0] remain_q, remain_d;
  logic [FADE_W-1:0]  fade_len_q;
  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               fading_q, last_q, past_q;
  logic               out_valid_q;
  logic [SAMPLE_BITS-1:0] left_out_q, right_out_q;
  logic               fading_out_q, last_out_q, past_out_q;

  logic               in_acc;
  logic               out_free;
  logic               done;
  logic               fade_now;
  lane_ctrl_t         ctrl;
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;

  assign s_tready = (state_q == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !out_valid_q || m_tready;
  assign done     = (state_q == ST_DIV) && (step_q == LAST_STEP);

  // Frame classification from the current count
  assign fade_now = (fade_len_q != '0) && (remain_q != '0) &&
                    (remain_q <= TRACK_W'(fade_len_q));

  // Lane control
  always_comb begin
    ctrl.load = in_acc;
    ctrl.mult = (state_q == ST_MUL);
    ctrl.step = (state_q == ST_DIV) && (step_q != LAST_STEP);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        if (step_q != LAST_STEP) begin
          step_d = step_q + 1'b1;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Frame counter: reload on a track length write, count down per frame
  always_comb begin
    remain_d = remain_q;
    if (cfg_we_i && (cfg_idx_i == REG_TRACK_LEN)) begin
      remain_d = cfg_data_i[TRACK_W-1:0];
    end else if (in_acc && (remain_q != '0)) begin
      remain_d = remain_q - 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      remain_q    <= '0;
      fade_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      remain_q <= remain_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TRACK_LEN: ;
          REG_FADE_LEN:  fade_len_q <= cfg_data_i[FADE_W-1:0];
          default: ;
        endcase
      end
      if (done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-frame flags, captured at acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fading_q <= fade_now;
      last_q   <= (remain_q == TRACK_W'(1));
      past_q   <= (remain_q == '0);
    end
  end

  // Left and right lanes
  lfog_lane u_lane_left (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (s_tdata[SAMPLE_BITS-1:0]),
    .fade_i   (fade_now),
    .num_i    (remain_q[FADE_W-1:0]),
    .den_i    (fade_len_q),
    .result_o (left_res)
  );

  lfog_lane u_lane_right (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .fade_i   (fade_now),
    .num_i    (remain_q[FADE_W-1:0]),
    .den_i    (fade_len_q),
    .result_o (right_res)
  );

  // Merge lane results and flags into the output register
  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      left_out_q   <= past_q ? '0 : left_res;
      right_out_q  <= past_q ? '0 : right_res;
      fading_out_q <= fading_q;
      last_out_q   <= last_q;
      past_out_q   <= past_q;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = TDATA_W'({right_out_q, left_out_q});
  assign m_tlast  = last_out_q;
  always_comb begin
    m_tuser                = '0;
    m_tuser[USER_FADING]   = fading_out_q;
    m_tuser[USER_PAST_END] = past_out_q;
  end

endmodule

@@ hdl/lfog_lane.sv @@
// ----------------------------------------------------------------------------
// lfog_lane
// One channel lane: sign split, a single multiply, then a bit-serial
// restoring divide giving one quotient bit per step.
// ----------------------------------------------------------------------------
module lfog_lane (
  input  logic                                 clk_i,
  input  lfog_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [lfog_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                 fade_i,
  input  logic [lfog_pkg::FADE_W-1:0]          num_i,
  input  logic [lfog_pkg::FADE_W-1:0]          den_i,
  output logic signed [lfog_pkg::SAMPLE_BITS-1:0] result_o
);
  import lfog_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   fade_q;
  logic [FADE_W-1:0]      num_q;
  logic [FADE_W-1:0]      den_q;
  logic [FADE_W-1:0]      rem_q;
  logic [SAMPLE_BITS-1:0] quo_q;

  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_W-1:0]      prod;
  logic [FADE_W:0]        rem_sh;
  logic [FADE_W:0]        rem_sub;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] quo_neg;

  // Magnitude of the held sample; the most negative value maps to 2^(n-1)
  assign neg  = sample_q[SAMPLE_BITS-1];
  assign mag  = neg ? (~sample_q + 1'b1) : sample_q;
  assign prod = PROD_W'(mag) * PROD_W'(num_q);

  // Restoring divide step: shift in the next product bit, subtract if it fits
  assign rem_sh  = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  // Operands and divide registers. The top product bits start as the
  // remainder: they stay below the divisor since remaining <= fade length.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= sample_i;
      fade_q   <= fade_i;
      num_q    <= num_i;
      den_q    <= den_i;
    end
    if (ctrl_i.mult) begin
      rem_q <= prod[PROD_W-1:SAMPLE_BITS];
      quo_q <= prod[SAMPLE_BITS-1:0];
    end else if (ctrl_i.step) begin
      rem_q <= ge ? rem_sub[FADE_W-1:0] : rem_sh[FADE_W-1:0];
      quo_q <= {quo_q[SAMPLE_BITS-2:0], ge};
    end
  end

  // Restore the sign, or pass the sample outside the fade region
  assign quo_neg  = ~quo_q + 1'b1;
  assign result_o = fade_q ? (neg ? quo_neg : quo_q) : sample_q;

endmodule

@@ hdl/lfog_checker.sv @@
// ----------------------------------------------------------------------------
// lfog_checker
// Port-level checks for the linear fade-out gain block, bound to the top.
// ----------------------------------------------------------------------------
module lfog_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lfog_pkg::TDATA_W-1:0]  m_tdata,
  input logic                          m_tlast,
  input logic [lfog_pkg::TUSER_W-1:0]  m_tuser
);
  import lfog_pkg::*;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // Past the end gives silence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[USER_PAST_END] |-> (m_tdata == '0))
    else $error("non-silent item past end of track");

  // Past the end is neither fading nor the last frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[USER_PAST_END] |-> !m_tlast && !m_tuser[USER_FADING])
    else $error("past-end item carries fading or last flag");

endmodule

bind linear_fade_out_gain lfog_checker u_lfog_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ verif/fade_checker.sv @@
// ----------------------------------------------------------------------------
// fade_checker
// Watches the register port and both streams of the linear fade-out gain
// block. It keeps its own copy of the track and fade registers and of the
// frame counter, predicts the result of every accepted frame, and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module fade_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lfog_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [lfog_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [lfog_pkg::TDATA_W-1:0]   s_tdata,   // left_in, right_in
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [lfog_pkg::TDATA_W-1:0]   m_tdata,   // left_out, right_out
  input  logic                           m_tlast,   // last_frame
  input  logic [lfog_pkg::TUSER_W-1:0]   m_tuser,   // fading, past_end
  output int                             fail_count_o,
  output int                             pending_o
);
  import lfog_pkg::*;

  localparam int S = SAMPLE_BITS;

  typedef struct packed {
    logic [S-1:0] left;
    logic [S-1:0] right;
    logic         fading;
    logic         last_frame;
    logic         past_end;
  } frame_res_t;

  // Frames still on their way out of the block, oldest first
  frame_res_t            due_frames[$];
  logic [TRACK_W-1:0]    track_len;
  logic [TRACK_W-1:0]    frames_left;
  logic [FADE_W-1:0]     fade_len;
  int                    fails;

  // Sample times num/den, magnitude truncated, sign restored
  function automatic logic [S-1:0] fade_sample(logic [S-1:0] smp, logic [TRACK_W-1:0] num,
                                               logic [FADE_W-1:0] den);
    logic [S:0]        mag;
    longint unsigned   wide_mag;
    longint unsigned   quot;
    logic [S-1:0]      q_trunc;
    mag      = smp[S-1] ? ({1'b0, ~smp} + 1'b1) : {1'b0, smp};
    wide_mag = mag;
    quot     = (wide_mag * num) / den;
    q_trunc  = quot[S-1:0];
    return smp[S-1] ? (~q_trunc + 1'b1) : q_trunc;
  endfunction

  // Expected result of one frame at the given counter and fade length
  function automatic frame_res_t faded_frame(logic [TDATA_W-1:0] d, logic [TRACK_W-1:0] remain,
                                             logic [FADE_W-1:0] fade);
    frame_res_t res;
    logic       in_fade;
    res = '0;
    if (remain == 0) begin
      res.past_end = 1'b1;
    end else begin
      in_fade = (fade != 0) && (remain <= fade);
      if (in_fade) begin
        res.left  = fade_sample(d[S-1:0], remain, fade);
        res.right = fade_sample(d[2*S-1:S], remain, fade);
      end else begin
        res.left  = d[S-1:0];
        res.right = d[2*S-1:S];
      end
      res.fading     = in_fade;
      res.last_frame = (remain == 1);
    end
    return res;
  endfunction

  // Track registers and frames, compare results
  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_res_t got;
    frame_res_t want;
    if (!rst_ni) begin
      track_len    = '0;
      fade_len     = '0;
      frames_left  = '0;
      fails        = 0;
      due_frames.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TRACK_LEN: begin
            track_len   = cfg_data_i[TRACK_W-1:0];
            frames_left = track_len;
          end
          REG_FADE_LEN: begin
            fade_len = cfg_data_i[FADE_W-1:0];
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        due_frames.push_back(faded_frame(s_tdata, frames_left, fade_len));
        if (frames_left != 0) frames_left = frames_left - 1;
      end
      if (m_tvalid && m_tready) begin
        got.left       = m_tdata[S-1:0];
        got.right      = m_tdata[2*S-1:S];
        got.fading     = m_tuser[USER_FADING];
        got.last_frame = m_tlast;
        got.past_end   = m_tuser[USER_PAST_END];
        if (due_frames.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected: L=%h R=%h fade=%b last=%b end=%b",
                   $time, got.left, got.right, got.fading, got.last_frame, got.past_end);
        end else begin
          want = due_frames.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch, expected L=%h R=%h fade=%b last=%b end=%b",
                     $time, want.left, want.right, want.fading, want.last_frame,
                     want.past_end);
            $display("%0t:           actual   L=%h R=%h fade=%b last=%b end=%b",
                     $time, got.left, got.right, got.fading, got.last_frame, got.past_end);
          end
        end
      end
      pending_o    <= due_frames.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear fade-out gain block. Directed frames
// cover silence after reset, pass-through, the fade region, a fade longer
// than the track, a fade length changed mid-track and the register maxima;
// then one long receiver hold-off, then random phases with random gaps on
// both streams and a drain between phases. Checking is done by fade_checker.
// ----------------------------------------------------------------------------
module tb;
  import lfog_pkg::*;

  localparam int S           = SAMPLE_BITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_FRAMES = 1350;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_tvalid   = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata    = '0;
  logic                 m_tvalid;
  logic                 m_tready   = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tlast;
  logic [TUSER_W-1:0]   m_tuser;

  int fail_count;
  int pending;
  int cycles    = 0;
  int sent      = 0;
  int corner_k  = 0;
  bit no_idle   = 1'b0;
  bit stall_rx  = 1'b0;

  logic [S-1:0] corner_smp [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001};

  linear_fade_out_gain DUT (.*);

  fade_checker u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock, period 20
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random gaps, one long hold-off on request
  initial begin : receiver
    int hold;
    forever begin
      if (stall_rx) begin
        stall_rx = 1'b0;
        hold     = 300;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(logic [S-1:0] l, logic [S-1:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [S-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return S'($urandom);
    endcase
  endfunction

  task automatic send_corner(int n);
    repeat (n) begin
      send_frame(corner_smp[corner_k % 6], corner_smp[(corner_k + 3) % 6]);
      corner_k++;
    end
    drain();
  endtask

  task automatic send_random(int n);
    repeat (n) send_frame(pick_sample(), pick_sample());
    drain();
  endtask

  initial begin : stimulus
    int          kind;
    int          n;
    logic [31:0] trk;
    logic [31:0] fd;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Counter is zero after reset: silence and past-end
    send_corner(2);

    // Fade disabled: pass-through, then past the end
    write_reg(REG_TRACK_LEN, 32'd5);
    write_reg(REG_FADE_LEN, 32'd0);
    send_corner(6);

    // Last four frames fade, then one past the end
    write_reg(REG_TRACK_LEN, 32'd6);
    write_reg(REG_FADE_LEN, 32'd4);
    send_corner(7);

    // Fade longer than the track: gain starts below one
    write_reg(REG_TRACK_LEN, 32'd3);
    write_reg(REG_FADE_LEN, 32'd8);
    send_corner(4);

    // Fade length changed mid-track, counter keeps running
    write_reg(REG_FADE_LEN, 32'd0);
    write_reg(REG_TRACK_LEN, 32'd3);
    send_corner(1);
    write_reg(REG_FADE_LEN, 32'd2);
    send_corner(2);

    // Register maxima; upper data bits of the fade write are dropped
    write_reg(REG_TRACK_LEN, 32'hFFFF_FFFF);
    write_reg(REG_FADE_LEN, 32'hFFFF_FFFF);
    send_corner(2);
    write_reg(REG_TRACK_LEN, 32'h00FF_FFFF);
    send_corner(2);

    // Long receiver hold-off while frames keep coming
    write_reg(REG_TRACK_LEN, 32'd30);
    write_reg(REG_FADE_LEN, 32'd12);
    no_idle  = 1'b1;
    stall_rx = 1'b1;
    send_random(30);

    // Random phases
    while (sent < RAND_FRAMES) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 5);
      case (kind)
        0: begin
          trk = $urandom_range(1, 40);
          write_reg(REG_FADE_LEN, 32'd0);
          write_reg(REG_TRACK_LEN, trk);
          n = trk + $urandom_range(0, 3);
        end
        1: begin
          trk = $urandom_range(1, 40);
          fd  = $urandom_range(1, trk);
          write_reg(REG_TRACK_LEN, trk);
          write_reg(REG_FADE_LEN, fd);
          n = trk + $urandom_range(0, 3);
        end
        2: begin
          trk = $urandom_range(1, 40);
          fd  = $urandom_range(trk + 1, 100);
          write_reg(REG_FADE_LEN, fd);
          write_reg(REG_TRACK_LEN, trk);
          n = trk + $urandom_range(0, 2);
        end
        3: begin
          // Deep in a long fade: arbitrary gain ratios
          fd  = $urandom_range(1, 24'hFF_FFFF);
          trk = $urandom_range(1, fd);
          write_reg(REG_FADE_LEN, {8'($urandom), fd[23:0]});
          write_reg(REG_TRACK_LEN, trk);
          n = $urandom_range(1, 6);
        end
        4: begin
          trk = $urandom;
          fd  = $urandom;
          write_reg(REG_TRACK_LEN, trk);
          write_reg(REG_FADE_LEN, fd);
          n = $urandom_range(1, 4);
        end
        default: begin
          // New fade length only, counter continues
          fd = $urandom_range(0, 40);
          write_reg(REG_FADE_LEN, fd);
          n = $urandom_range(1, 10);
        end
      endcase
      send_random(n);
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lfog_pkg.sv
hdl/lfog_lane.sv
hdl/linear_fade_out_gain.sv
hdl/lfog_checker.sv
verif/fade_checker.sv
verif/tb.sv
